>>> design/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, types and ring index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int ENTRIES_W  = 5;
    localparam int STATUS_W   = 2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    function automatic t_idx ring_add(input t_idx base, input t_cnt off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    function automatic t_idx ring_inc(input t_idx base);
        return (base == IDX_W'(DEPTH - 1)) ? '0 : base + IDX_W'(1);
    endfunction

    function automatic t_idx ring_dec(input t_idx base);
        return (base == '0) ? IDX_W'(DEPTH - 1) : base - IDX_W'(1);
    endfunction

endpackage

>>> design/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque on a ring of RAM slots with front index and entry count.
// The slot read is registered in the RAM, then the result word is loaded
// into the output reg; no new request is taken until that load is done.
// A new request is taken while the previous result waits in the output reg.
// Reset: synchronous, active low; clears front index, count and handshakes.
// Slot contents are not cleared; only occupied slots are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [VALUE_W-1:0]    i_push_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VALUE_W-1:0]    o_out_value,
    output logic                  o_is_empty,
    output logic [ENTRIES_W-1:0]  o_entries,
    output logic [STATUS_W-1:0]   o_status
);

    t_state  r_state, n_state;
    t_idx    r_front, n_front;
    t_cnt    r_count, n_count;
    logic    r_pend_rd, n_pend_rd;
    t_status r_pend_status, n_pend_status;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_is_empty;
    logic [ENTRIES_W-1:0]  r_entries;
    t_status               r_status;

    logic                  we, re, load_out;
    t_idx                  waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;

    assign wdata = DATA_WIDTH'(i_push_value);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_front       <= '0;
            r_count       <= '0;
            r_pend_rd     <= 1'b0;
            r_pend_status <= STAT_OK;
        end else begin
            r_state       <= n_state;
            r_front       <= n_front;
            r_count       <= n_count;
            r_pend_rd     <= n_pend_rd;
            r_pend_status <= n_pend_status;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_pend_rd     = r_pend_rd;
        n_pend_status = r_pend_status;
        we            = 1'b0;
        waddr         = r_front;
        re            = 1'b0;
        raddr         = r_front;
        o_ready       = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state       = ST_READ;
                    n_pend_rd     = 1'b0;
                    n_pend_status = STAT_OK;
                    case (t_func'(i_func))
                        FN_PUSH_FRONT, FN_PUSH_BACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_pend_status = STAT_OVERFLOW;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (t_func'(i_func) == FN_PUSH_FRONT) begin
                                    n_front = ring_dec(r_front);
                                    waddr   = ring_dec(r_front);
                                end else begin
                                    waddr   = ring_add(r_front, r_count);
                                end
                            end
                        end
                        FN_POP_FRONT, FN_PEEK_FRONT: begin
                            if (r_count == '0) begin
                                n_pend_status = STAT_UNDERFLOW;
                            end else begin
                                re        = 1'b1;
                                n_pend_rd = 1'b1;
                                raddr     = r_front;
                                if (t_func'(i_func) == FN_POP_FRONT) begin
                                    n_front = ring_inc(r_front);
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                        end
                        FN_POP_BACK, FN_PEEK_BACK: begin
                            if (r_count == '0) begin
                                n_pend_status = STAT_UNDERFLOW;
                            end else begin
                                re        = 1'b1;
                                n_pend_rd = 1'b1;
                                raddr     = ring_add(r_front, r_count - CNT_W'(1));
                                if (t_func'(i_func) == FN_POP_BACK) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= r_pend_rd ? VALUE_W'(rdata) : '0;
            r_is_empty  <= (r_count == '0);
            r_entries   <= ENTRIES_W'(r_count);
            r_status    <= r_pend_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_is_empty  = r_is_empty;
    assign o_entries   = r_entries;
    assign o_status    = r_status;

endmodule

>>> design/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue. A directed table covers the
// empty and full edges, both ends and the unused codes, then random request
// runs drift the fill level between empty and full under three idle
// profiles and one long output stall. Every result word is checked field by
// field against the table's expected word or an in-bench deque model.
// ----------------------------------------------------------------------------
module tb;
    import deq_pkg::*;

    localparam int          HALF_PERIOD = 5;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 80;
    localparam int          PHASE_ITEMS = 300;
    localparam int          PLAN_ROWS   = 21;
    localparam logic [2:0]  FN_SPARE_6  = 3'd6;
    localparam logic [2:0]  FN_SPARE_7  = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 empty;
        logic [ENTRIES_W-1:0] entries;
        logic [STATUS_W-1:0]  status;
    } t_dq_result;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        logic               typed;
        t_dq_result         want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [VALUE_W-1:0]   i_push_value = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [VALUE_W-1:0]   o_out_value;
    logic                 o_is_empty;
    logic [ENTRIES_W-1:0] o_entries;
    logic [STATUS_W-1:0]  o_status;

    // model state
    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    t_idx                  head = '0;
    t_cnt                  fill = '0;

    t_dq_result pending_results [$];
    int         mismatches = 0;
    int         stall_cycles = 0;
    int         send_idle = 12;
    int         recv_idle = 70;
    bit         hold_req = 1'b0;

    t_stim_row plan [PLAN_ROWS] = '{
        '{FN_POP_FRONT,  32'h0,        5'd1, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_UNDERFLOW}},
        '{FN_POP_BACK,   32'h0,        5'd1, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_UNDERFLOW}},
        '{FN_PEEK_FRONT, 32'hFFFFFFFF, 5'd1, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_UNDERFLOW}},
        '{FN_PEEK_BACK,  32'h0,        5'd1, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_UNDERFLOW}},
        '{FN_PUSH_FRONT, 32'hFFFFFFFF, 5'd1, 1'b1, '{32'h0, 1'b0, 5'd1, STAT_OK}},
        '{FN_PUSH_BACK,  32'h0,        5'd1, 1'b1, '{32'h0, 1'b0, 5'd2, STAT_OK}},
        '{FN_PEEK_FRONT, 32'h0,        5'd1, 1'b1, '{32'hFFFFFFFF, 1'b0, 5'd2, STAT_OK}},
        '{FN_PEEK_BACK,  32'hFFFFFFFF, 5'd1, 1'b1, '{32'h0, 1'b0, 5'd2, STAT_OK}},
        '{FN_SPARE_6,    32'hA5A5A5A5, 5'd1, 1'b1, '{32'h0, 1'b0, 5'd2, STAT_OK}},
        '{FN_SPARE_7,    32'h5A5A5A5A, 5'd1, 1'b1, '{32'h0, 1'b0, 5'd2, STAT_OK}},
        '{FN_POP_FRONT,  32'h0,        5'd1, 1'b1, '{32'hFFFFFFFF, 1'b0, 5'd1, STAT_OK}},
        '{FN_POP_BACK,   32'h0,        5'd1, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_OK}},
        '{FN_PUSH_FRONT, 32'h80000001, 5'd8, 1'b0, '0},
        '{FN_PUSH_BACK,  32'h00000100, 5'd8, 1'b0, '0},
        '{FN_PUSH_BACK,  32'hDEADBEEF, 5'd1, 1'b1, '{32'h0, 1'b0, 5'd16, STAT_OVERFLOW}},
        '{FN_PUSH_FRONT, 32'h0,        5'd1, 1'b1, '{32'h0, 1'b0, 5'd16, STAT_OVERFLOW}},
        '{FN_PEEK_FRONT, 32'h0,        5'd1, 1'b0, '0},
        '{FN_PEEK_BACK,  32'h0,        5'd1, 1'b0, '0},
        '{FN_POP_BACK,   32'h0,        5'd8, 1'b0, '0},
        '{FN_POP_FRONT,  32'h0,        5'd8, 1'b0, '0},
        '{FN_POP_FRONT,  32'h0,        5'd1, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_UNDERFLOW}}
    };

    double_ended_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_value  (o_out_value),
        .o_is_empty   (o_is_empty),
        .o_entries    (o_entries),
        .o_status     (o_status)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic deque_step(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                              output t_dq_result r);
        t_idx back;
        r = '0;
        r.status = STAT_OK;
        case (f)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (fill == t_cnt'(DEPTH)) begin
                    r.status = STAT_OVERFLOW;
                end else if (f == FN_PUSH_FRONT) begin
                    head = head - t_idx'(1);
                    ring_mem[head] = v;
                    fill = fill + t_cnt'(1);
                end else begin
                    ring_mem[head + t_idx'(fill)] = v;
                    fill = fill + t_cnt'(1);
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
                if (fill == '0) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    back = head + t_idx'(fill - t_cnt'(1));
                    if (f == FN_POP_FRONT || f == FN_PEEK_FRONT) begin
                        r.value = ring_mem[head];
                    end else begin
                        r.value = ring_mem[back];
                    end
                    if (f == FN_POP_FRONT) begin
                        head = head + t_idx'(1);
                        fill = fill - t_cnt'(1);
                    end else if (f == FN_POP_BACK) begin
                        fill = fill - t_cnt'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        r.empty   = (fill == '0);
        r.entries = ENTRIES_W'(fill);
    endtask

    // entered and left at a falling edge
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                                input logic typed, input t_dq_result want);
        t_dq_result pred;
        while ($urandom_range(99) < send_idle) begin
            i_valid      = 1'b0;
            i_func       = FUNC_W'($urandom);
            i_push_value = $urandom;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_func       = f;
        i_push_value = v;
        do @(posedge i_clk); while (!o_ready);
        deque_step(f, v, pred);
        pending_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // receiver: random backpressure, one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_dq_result want;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: value=%h empty=%b entries=%0d status=%0d",
                             o_out_value, o_is_empty, o_entries, o_status);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_value !== want.value || o_is_empty !== want.empty ||
                    o_entries !== want.entries || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: want value=%h empty=%b entries=%0d status=%0d",
                                 want.value, want.empty, want.entries, want.status);
                        $display("          got  value=%h empty=%b entries=%0d status=%0d",
                                 o_out_value, o_is_empty, o_entries, o_status);
                    end
                end
            end
        end
    end

    initial begin
        int                 mode;
        int                 run_left;
        int                 push_pct;
        int                 pop_pct;
        int                 r;
        logic [FUNC_W-1:0]  f;
        logic [VALUE_W-1:0] v;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            for (int k = 0; k < int'(plan[i].reps); k++) begin
                send_request(plan[i].func, plan[i].value + VALUE_W'(k), plan[i].typed,
                             plan[i].want);
            end
        end

        run_left = 0;
        mode     = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 12;
                    recv_idle = 70;
                end
                1: begin
                    send_idle = 70;
                    recv_idle = 12;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    hold_req  = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (run_left == 0) begin
                    mode     = $urandom_range(2);
                    run_left = $urandom_range(40, 8);
                end
                run_left--;
                // fill-biased runs push the deque to full, drain runs to empty
                case (mode)
                    0: begin
                        push_pct = 70;
                        pop_pct  = 15;
                    end
                    1: begin
                        push_pct = 15;
                        pop_pct  = 70;
                    end
                    default: begin
                        push_pct = 40;
                        pop_pct  = 35;
                    end
                endcase
                r = $urandom_range(99);
                if (r < push_pct) begin
                    f = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
                end else if (r < push_pct + pop_pct) begin
                    f = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
                end else if (r < 96) begin
                    f = $urandom_range(1) ? FN_PEEK_BACK : FN_PEEK_FRONT;
                end else begin
                    f = $urandom_range(1) ? FN_SPARE_7 : FN_SPARE_6;
                end
                case ($urandom_range(15))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = $urandom;
                endcase
                send_request(f, v, 1'b0, '0);
            end
        end

        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
